FILE: hdl/vnorm_pkg.sv
`timescale 1ns / 1ps
package vnorm_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int OUTPUT_FRACTION_BITS = 14;
  localparam int SQ_BITS = 2 * COMPONENT_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int MAG_BITS = COMPONENT_BITS;
  localparam int DIVIDEND_BITS = MAG_BITS + OUTPUT_FRACTION_BITS;
  localparam int QUOT_BITS = OUTPUT_FRACTION_BITS + 1;
  localparam int UNIT_BITS = 16;
  localparam int LENGTH_BITS = 17;

  typedef logic [MAG_BITS-1:0] mag_t;
  typedef logic [SUM_BITS-1:0] sum_t;
  typedef logic [ROOT_BITS-1:0] root_t;

  typedef struct packed {
    logic valid;
    logic [2:0] neg;
    mag_t [2:0] mag;
  } carry_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0] unit_x;
    logic signed [UNIT_BITS-1:0] unit_y;
    logic signed [UNIT_BITS-1:0] unit_z;
    logic [LENGTH_BITS-1:0] length;
    logic zero_vector;
  } result_t;

endpackage

FILE: hdl/vnorm_if.sv
`timescale 1ns / 1ps
interface vnorm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] vec_x;
  logic signed [15:0] vec_y;
  logic signed [15:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vnorm_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic [16:0] length;
  logic zero_vector;
  modport source (output valid, unit_x, unit_y, unit_z, length, zero_vector, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, length, zero_vector, output ready);
endinterface

FILE: hdl/vector3_normalise.sv
`timescale 1ns / 1ps
// Normalizes a signed Q8.8 3-vector to Q1.14 unit components and returns
// its Q8.8 length (floor square root of the sum of squares).
// Channels: in_ch (sink) carries vec_x/vec_y/vec_z; out_ch (source)
// carries unit_x/unit_y/unit_z, length and zero_vector. A word moves when
// valid and ready are both high.
// Throughput: one word per cycle unless the receiver stalls. Pipeline:
// a register for the squares, 17 square root cells (one result bit each),
// 15 divider cells (one quotient bit for all three components each) and a
// result register.
// The whole chain advances together; when the receiver stalls with a
// word held in the output register the chain freezes and in_ch.ready
// drops, otherwise new words enter every cycle.
// A zero vector yields zero components, zero length and zero_vector high.
// Reset (rst, synchronous) clears every valid bit; no words are in flight.
module vector3_normalise (
  input  logic    clk,
  input  logic    rst,
  vnorm_in_if.sink    in_ch,
  vnorm_out_if.source out_ch
);
  import vnorm_pkg::*;

  logic    en;
  carry_t  c0;
  sum_t    sum0;
  logic [2:0] neg_in;
  mag_t [2:0] mag_in;

  carry_t  sc [ROOT_BITS+1];
  sum_t    sr [ROOT_BITS+1];
  root_t   sq [ROOT_BITS+1];

  logic        dv [QUOT_BITS+1];
  root_t       dd [QUOT_BITS+1];
  logic [2:0]  dn [QUOT_BITS+1];
  logic [2:0][DIVIDEND_BITS-1:0] drm [QUOT_BITS+1];
  logic [2:0][QUOT_BITS-1:0]     dq [QUOT_BITS+1];

  result_t res;
  logic    res_valid;

  assign en = !res_valid || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    neg_in[0] = in_ch.vec_x[COMPONENT_BITS-1];
    neg_in[1] = in_ch.vec_y[COMPONENT_BITS-1];
    neg_in[2] = in_ch.vec_z[COMPONENT_BITS-1];
    mag_in[0] = neg_in[0] ? mag_t'(-in_ch.vec_x) : mag_t'(in_ch.vec_x);
    mag_in[1] = neg_in[1] ? mag_t'(-in_ch.vec_y) : mag_t'(in_ch.vec_y);
    mag_in[2] = neg_in[2] ? mag_t'(-in_ch.vec_z) : mag_t'(in_ch.vec_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c0.valid <= 1'b0;
    end else if (en) begin
      c0.valid <= in_ch.valid;
    end
    if (en) begin
      c0.neg <= neg_in;
      c0.mag <= mag_in;
      sum0 <= sum_t'(SQ_BITS'(mag_in[0]) * SQ_BITS'(mag_in[0]))
            + sum_t'(SQ_BITS'(mag_in[1]) * SQ_BITS'(mag_in[1]))
            + sum_t'(SQ_BITS'(mag_in[2]) * SQ_BITS'(mag_in[2]));
    end
  end

  assign sc[0] = c0;
  assign sr[0] = sum0;
  assign sq[0] = '0;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
    vnorm_sqrt_cell u_cell (
      .clk, .rst, .en,
      .step   (6'(ROOT_BITS - 1 - g)),
      .c_in   (sc[g]),
      .rem_in (sr[g]),
      .root_in(sq[g]),
      .c_out  (sc[g+1]),
      .rem_out(sr[g+1]),
      .root_out(sq[g+1])
    );
  end

  assign dv[0] = sc[ROOT_BITS].valid;
  assign dd[0] = sq[ROOT_BITS];
  assign dn[0] = sc[ROOT_BITS].neg;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drm[0][i] = {sc[ROOT_BITS].mag[i], {OUTPUT_FRACTION_BITS{1'b0}}};
      dq[0][i] = '0;
    end
  end

  for (genvar g = 0; g < QUOT_BITS; g++) begin : g_div
    vnorm_div_cell u_cell (
      .clk, .rst, .en,
      .step   (5'(QUOT_BITS - 1 - g)),
      .v_in   (dv[g]),
      .den_in (dd[g]),
      .neg_in (dn[g]),
      .rem_in (drm[g]),
      .q_in   (dq[g]),
      .v_out  (dv[g+1]),
      .den_out(dd[g+1]),
      .neg_out(dn[g+1]),
      .rem_out(drm[g+1]),
      .q_out  (dq[g+1])
    );
  end

  logic zero_len;
  logic [2:0][UNIT_BITS-1:0] unit;
  assign zero_len = dd[QUOT_BITS] == '0;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit[i] = dn[QUOT_BITS][i] ? UNIT_BITS'(-{1'b0, dq[QUOT_BITS][i]})
                                 : UNIT_BITS'(dq[QUOT_BITS][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dv[QUOT_BITS];
    end
    if (en) begin
      res.unit_x <= zero_len ? '0 : unit[0];
      res.unit_y <= zero_len ? '0 : unit[1];
      res.unit_z <= zero_len ? '0 : unit[2];
      res.length <= LENGTH_BITS'(dd[QUOT_BITS]);
      res.zero_vector <= zero_len;
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.unit_x = res.unit_x;
  assign out_ch.unit_y = res.unit_y;
  assign out_ch.unit_z = res.unit_z;
  assign out_ch.length = res.length;
  assign out_ch.zero_vector = res.zero_vector;
endmodule

FILE: hdl/vnorm_sqrt_cell.sv
`timescale 1ns / 1ps
module vnorm_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [5:0]         step,
  input  vnorm_pkg::carry_t  c_in,
  input  vnorm_pkg::sum_t    rem_in,
  input  vnorm_pkg::root_t   root_in,
  output vnorm_pkg::carry_t  c_out,
  output vnorm_pkg::sum_t    rem_out,
  output vnorm_pkg::root_t   root_out
);
  import vnorm_pkg::*;

  logic [SUM_BITS+1:0] trial;
  logic [SUM_BITS+1:0] rem_ext;
  logic [SUM_BITS+1:0] bitv;
  logic                take;

  always_comb begin
    bitv = '0;
    bitv[2*step] = 1'b1;
    rem_ext = {2'b00, rem_in};
    trial = ({2'b00, root_in} << ({step, 1'b0} + 7'd2)) | bitv;
    take = rem_ext >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else if (en) begin
      c_out.valid <= c_in.valid;
    end
    if (en) begin
      c_out.neg <= c_in.neg;
      c_out.mag <= c_in.mag;
      rem_out <= take ? SUM_BITS'(rem_ext - trial) : rem_in;
      root_out <= {root_in[ROOT_BITS-2:0], take};
    end
  end
endmodule

FILE: hdl/vnorm_div_cell.sv
`timescale 1ns / 1ps
module vnorm_div_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [4:0]                            step,
  input  logic                                  v_in,
  input  vnorm_pkg::root_t                      den_in,
  input  logic [2:0]                            neg_in,
  input  logic [2:0][vnorm_pkg::DIVIDEND_BITS-1:0] rem_in,
  input  logic [2:0][vnorm_pkg::QUOT_BITS-1:0]  q_in,
  output logic                                  v_out,
  output vnorm_pkg::root_t                      den_out,
  output logic [2:0]                            neg_out,
  output logic [2:0][vnorm_pkg::DIVIDEND_BITS-1:0] rem_out,
  output logic [2:0][vnorm_pkg::QUOT_BITS-1:0]  q_out
);
  import vnorm_pkg::*;

  logic [2:0][DIVIDEND_BITS+QUOT_BITS-1:0] shifted;
  logic [2:0]                              take;
  logic [DIVIDEND_BITS+QUOT_BITS-1:0]      den_ext;

  always_comb begin
    den_ext = (DIVIDEND_BITS+QUOT_BITS)'(den_in) << step;
    for (int i = 0; i < 3; i++) begin
      shifted[i] = (DIVIDEND_BITS+QUOT_BITS)'(rem_in[i]);
      take[i] = shifted[i] >= den_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      den_out <= den_in;
      neg_out <= neg_in;
      for (int i = 0; i < 3; i++) begin
        rem_out[i] <= take[i] ? DIVIDEND_BITS'(shifted[i] - den_ext) : rem_in[i];
        q_out[i] <= {q_in[i][QUOT_BITS-2:0], take[i]};
      end
    end
  end
endmodule
